/* design/lps_pkg.sv */
// lps_pkg: shared constants, state encoding and controller/datapath link types
// for the line pixel stepper. no dependencies.

package lps_pkg;

  localparam int COORD_BITS_DEFAULT = 10;

  // request action codes
  localparam logic ACT_START = 1'b0;
  localparam logic ACT_STEP  = 1'b1;

  typedef enum logic {
    ST_IDLE,
    ST_WALK
  } lps_state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic step;
  } lps_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_last;
  } lps_sts_t;

endpackage

/* design/lps_if.sv */
// lps_in_if / lps_out_if: valid-ready channels for line requests and pixels.
// depends on lps_pkg for the default coordinate width.

interface lps_in_if #(
  parameter int COORD_BITS = lps_pkg::COORD_BITS_DEFAULT
) ();
  logic                  valid;
  logic                  ready;
  logic                  action;
  logic [COORD_BITS-1:0] x_start;
  logic [COORD_BITS-1:0] y_start;
  logic [COORD_BITS-1:0] x_end;
  logic [COORD_BITS-1:0] y_end;

  modport source (output valid, action, x_start, y_start, x_end, y_end, input ready);
  modport sink   (input valid, action, x_start, y_start, x_end, y_end, output ready);
endinterface

interface lps_out_if #(
  parameter int COORD_BITS = lps_pkg::COORD_BITS_DEFAULT
) ();
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] pixel_x;
  logic [COORD_BITS-1:0] pixel_y;
  logic                  last;

  modport source (output valid, pixel_x, pixel_y, last, input ready);
  modport sink   (input valid, pixel_x, pixel_y, last, output ready);
endinterface

/* design/lps_ctrl.sv */
// lps_ctrl: line walk state machine, request handshake and output valid flag.
// depends on lps_pkg for state, command and status types.

module lps_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_action,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output lps_pkg::lps_cmd_t cmd,
  input  lps_pkg::lps_sts_t sts
);

  lps_pkg::lps_state_t state_r, state_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                accept;

  // a request may enter whenever the output slot is free or being drained
  assign in_ready  = !out_valid_r || out_ready;
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lps_pkg::ST_IDLE: begin
        if (accept && in_action == lps_pkg::ACT_START) state_nxt = lps_pkg::ST_WALK;
      end
      lps_pkg::ST_WALK: begin
        if (accept && in_action == lps_pkg::ACT_START) begin
          state_nxt = lps_pkg::ST_WALK;
        end else if (accept && sts.is_last) begin
          state_nxt = lps_pkg::ST_IDLE;
        end
      end
      default: state_nxt = lps_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd.load = 1'b0;
    cmd.step = 1'b0;
    unique case (state_r)
      lps_pkg::ST_IDLE: begin
        cmd.load = accept && in_action == lps_pkg::ACT_START;
      end
      lps_pkg::ST_WALK: begin
        cmd.load = accept && in_action == lps_pkg::ACT_START;
        cmd.step = accept && in_action == lps_pkg::ACT_STEP;
      end
      default: begin
        cmd.load = 1'b0;
        cmd.step = 1'b0;
      end
    endcase
  end

  always_comb begin
    if (cmd.step) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lps_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_load_walks: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> state_r == lps_pkg::ST_WALK)
    else $error("start request did not enter walk");

  a_last_idles: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step && sts.is_last |=> state_r == lps_pkg::ST_IDLE)
    else $error("final pixel did not end the line");

  a_step_fills: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |=> out_valid_r)
    else $error("pixel step produced no output");

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid_r)
    else $error("request stalled with empty output slot");

endmodule

/* design/lps_dp.sv */
// lps_dp: line setup, major/minor coordinate walk with rounding remainder,
// and the registered pixel output. depends on lps_pkg for command/status types.

module lps_dp #(
  parameter int COORD_BITS = lps_pkg::COORD_BITS_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  lps_pkg::lps_cmd_t     cmd,
  output lps_pkg::lps_sts_t     sts,
  input  logic [COORD_BITS-1:0] x_start,
  input  logic [COORD_BITS-1:0] y_start,
  input  logic [COORD_BITS-1:0] x_end,
  input  logic [COORD_BITS-1:0] y_end,
  output logic [COORD_BITS-1:0] pixel_x,
  output logic [COORD_BITS-1:0] pixel_y,
  output logic                  last
);

  localparam int N = COORD_BITS;
  localparam int W = COORD_BITS + 3;

  logic                steep_r, steep_nxt;
  logic [N-1:0]        end_major_r, end_major_nxt;
  logic [N:0]          dmaj_r, dmaj_nxt;
  logic signed [N:0]   dmin_r, dmin_nxt;
  logic [N-1:0]        cur_major_r, cur_major_nxt;
  logic [N-1:0]        cur_minor_r, cur_minor_nxt;
  logic [N:0]          rem_r, rem_nxt;
  logic [N-1:0]        px_r, py_r;
  logic                last_r;

  // setup
  logic signed [W-1:0] dx, dy, adx, ady;
  logic                steep_in;
  logic [N-1:0]        a0, b0, a1, b1;
  logic [N-1:0]        ma0, mb0, ma1, mb1;

  // walk
  logic signed [W-1:0] sum, span;
  logic                is_last;

  assign dx  = $signed({3'b000, x_end}) - $signed({3'b000, x_start});
  assign dy  = $signed({3'b000, y_end}) - $signed({3'b000, y_start});
  assign adx = dx[W-1] ? -dx : dx;
  assign ady = dy[W-1] ? -dy : dy;
  // vertical, single point and slope of one all walk in y
  assign steep_in = (dx == '0) || !(ady < adx);

  always_comb begin
    if (steep_in) begin
      a0 = y_start; b0 = x_start; a1 = y_end; b1 = x_end;
    end else begin
      a0 = x_start; b0 = y_start; a1 = x_end; b1 = y_end;
    end
    if (a0 > a1) begin
      ma0 = a1; mb0 = b1; ma1 = a0; mb1 = b0;
    end else begin
      ma0 = a0; mb0 = b0; ma1 = a1; mb1 = b1;
    end
  end

  assign is_last     = cur_major_r == end_major_r;
  assign sts.is_last = is_last;

  assign sum  = $signed({2'b00, rem_r}) + $signed({dmin_r[N], dmin_r, 1'b0});
  assign span = $signed({1'b0, dmaj_r, 1'b0});

  always_comb begin
    steep_nxt     = steep_r;
    end_major_nxt = end_major_r;
    dmaj_nxt      = dmaj_r;
    dmin_nxt      = dmin_r;
    cur_major_nxt = cur_major_r;
    cur_minor_nxt = cur_minor_r;
    rem_nxt       = rem_r;
    if (cmd.load) begin
      steep_nxt     = steep_in;
      end_major_nxt = ma1;
      dmaj_nxt      = {1'b0, ma1} - {1'b0, ma0};
      dmin_nxt      = $signed({1'b0, mb1}) - $signed({1'b0, mb0});
      cur_major_nxt = ma0;
      cur_minor_nxt = mb0;
      rem_nxt       = {1'b0, ma1} - {1'b0, ma0};
    end else if (cmd.step && !is_last) begin
      cur_major_nxt = cur_major_r + 1'b1;
      // remainder moves by at most one span, one correction is enough
      if (sum >= span) begin
        rem_nxt       = (N+1)'(sum - span);
        cur_minor_nxt = cur_minor_r + 1'b1;
      end else if (sum < 0) begin
        rem_nxt       = (N+1)'(sum + span);
        cur_minor_nxt = cur_minor_r - 1'b1;
      end else begin
        rem_nxt = (N+1)'(sum);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      steep_r     <= 1'b0;
      end_major_r <= '0;
      dmaj_r      <= '0;
      dmin_r      <= '0;
      cur_major_r <= '0;
      cur_minor_r <= '0;
      rem_r       <= '0;
    end else begin
      steep_r     <= steep_nxt;
      end_major_r <= end_major_nxt;
      dmaj_r      <= dmaj_nxt;
      dmin_r      <= dmin_nxt;
      cur_major_r <= cur_major_nxt;
      cur_minor_r <= cur_minor_nxt;
      rem_r       <= rem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step) begin
      px_r   <= steep_r ? cur_minor_r : cur_major_r;
      py_r   <= steep_r ? cur_major_r : cur_minor_r;
      last_r <= is_last;
    end
  end

  assign pixel_x = px_r;
  assign pixel_y = py_r;
  assign last    = last_r;

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, rem_r} <= {dmaj_r, 1'b0})
    else $error("rounding remainder out of range");

  a_major_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cur_major_r <= end_major_r)
    else $error("walk passed the end of the line");

  a_minor_slope: assert property (@(posedge clk) disable iff (!rst_n)
    $signed({dmin_r[N], dmin_r}) <= $signed({1'b0, dmaj_r}) &&
    $signed({dmin_r[N], dmin_r}) >= -$signed({1'b0, dmaj_r}))
    else $error("minor delta exceeds major delta");

endmodule

/* design/line_pixel_stepper_top.sv */
// line pixel stepper: a start request latches the endpoints and gives no pixel;
// each step request in a walk gives the next pixel in the cycle after acceptance.
// throughput is one request per cycle unless the output stalls; each request moves
// the walk one major step by one add/compare/correct on the rounding remainder.
// a stalled output holds its pixel while one more request waits at the input.
// synchronous reset clears the walk state and the output valid; no line is active.
// depends on lps_pkg, lps_if, lps_ctrl and lps_dp

module line_pixel_stepper_top #(
  parameter int COORD_BITS = lps_pkg::COORD_BITS_DEFAULT
) (
  input logic        clk,
  input logic        rst_n,
  lps_in_if.sink     in_ch,
  lps_out_if.source  out_ch
);

  lps_pkg::lps_cmd_t cmd;
  lps_pkg::lps_sts_t sts;

  lps_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_action (in_ch.action),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  lps_dp #(
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .sts     (sts),
    .x_start (in_ch.x_start),
    .y_start (in_ch.y_start),
    .x_end   (in_ch.x_end),
    .y_end   (in_ch.y_end),
    .pixel_x (out_ch.pixel_x),
    .pixel_y (out_ch.pixel_y),
    .last    (out_ch.last)
  );

endmodule
